### src/atta_pkg.sv
// types, constants and helpers shared by the adaptive tick time accumulator
// no dependencies
package atta_pkg;

  localparam int unsigned US_PER_MS = 1000;
  localparam int unsigned DIV_STEPS = 25;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic        cmd;
    logic [23:0] elapsed_us;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] ms_in_frame;
    logic [31:0] total_ms;
    logic [23:0] us_per_interrupt;
    logic [31:0] frame_ms;
  } out_beat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIN,
    S_EMIT
  } state_t;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_FRAME = 1'b1;

  localparam logic REG_PERIOD_VALUE = 1'b0;
  localparam logic REG_PERIOD_IN_MS = 1'b1;

  // nominal period in microseconds
  function automatic logic [23:0] nominal_us(input logic [9:0] value, input logic in_ms);
    logic [19:0] scaled;
    scaled = 20'(value) * 20'(US_PER_MS);
    return in_ms ? 24'(scaled) : 24'(value);
  endfunction

endpackage

### src/adaptive_tick_time_accumulator.sv
// top level of the adaptive tick time accumulator: bit-serial divider and state
// depends on atta_pkg
// a tick beat is divided step by step in S_DIV, then passes S_FIN and S_EMIT; a frame beat with
// interrupts seen does the same; one with none skips the division and goes to S_FIN
// one item at a time: in_stall stays high until the result has left S_EMIT
// reset: counts and totals clear, period is 1 ms, estimate 1000 us per interrupt
module adaptive_tick_time_accumulator
  import atta_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data,
  input  logic      cfg_write,
  input  logic      cfg_index,
  input  logic [9:0] cfg_data
);

  state_t state, state_next;

  logic [9:0]  period_value;
  logic        period_in_ms;
  logic [9:0]  acc;
  logic [31:0] frame_cnt;
  logic [31:0] total_cnt;
  logic [15:0] irq_cnt;
  logic [23:0] est;
  logic [31:0] finished;
  logic        cmd_r;

  // divider registers
  logic [15:0]       divisor;
  logic [15:0]       rem;
  logic [24:0]       quo;
  logic [STEP_W-1:0] step;

  logic [16:0] trial;
  logic        q_bit;
  logic        in_accept;
  logic        out_free;
  logic        skip_div;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign skip_div  = (in_data.cmd == CMD_FRAME) && (irq_cnt == 16'd0);

  // one restoring step
  always_comb begin
    trial = {rem, quo[24]};
    q_bit = (trial >= {1'b0, divisor});
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_accept) state_next = skip_div ? S_FIN : S_DIV;
      S_DIV:  if (step == STEP_W'(DIV_STEPS - 1)) state_next = S_FIN;
      S_FIN:  state_next = S_EMIT;
      S_EMIT: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall = (state != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // timekeeping state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      period_value <= 10'd1;
      period_in_ms <= 1'b1;
      acc          <= '0;
      frame_cnt    <= '0;
      total_cnt    <= '0;
      irq_cnt      <= '0;
      est          <= nominal_us(10'd1, 1'b1);
    end else begin
      if (in_accept) begin
        if (in_data.cmd == CMD_TICK) begin
          if (irq_cnt != 16'hFFFF) irq_cnt <= irq_cnt + 16'd1;
        end else begin
          frame_cnt <= '0;
          acc       <= '0;
          total_cnt <= total_cnt + frame_cnt;
          irq_cnt   <= '0;
          if (irq_cnt == 16'd0) est <= nominal_us(period_value, period_in_ms);
        end
      end
      // fold in the quotient and remainder
      if (state == S_FIN && !(cmd_r == CMD_FRAME && divisor == 16'd0)) begin
        if (cmd_r == CMD_TICK) begin
          frame_cnt <= frame_cnt + 32'(quo);
          acc       <= rem[9:0];
        end else begin
          est <= quo[23:0];
        end
      end
      if (cfg_write) begin
        unique case (cfg_index)
          REG_PERIOD_VALUE: begin
            period_value <= cfg_data;
            est          <= nominal_us(cfg_data, period_in_ms);
          end
          REG_PERIOD_IN_MS: begin
            period_in_ms <= cfg_data[0];
            est          <= nominal_us(period_value, cfg_data[0]);
          end
          default: ;
        endcase
      end
    end
  end

  // serial divider, dividend shifts out msb first as quotient shifts in
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r    <= in_data.cmd;
      finished <= frame_cnt;
      rem      <= '0;
      step     <= '0;
      if (in_data.cmd == CMD_TICK) begin
        quo     <= 25'(acc) + 25'(est);
        divisor <= 16'(US_PER_MS);
      end else begin
        quo     <= 25'(in_data.elapsed_us);
        divisor <= irq_cnt;
      end
    end else if (state == S_DIV) begin
      rem  <= q_bit ? 16'(trial - {1'b0, divisor}) : trial[15:0];
      quo  <= {quo[23:0], q_bit};
      step <= step + STEP_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      out_data.ms_in_frame      <= frame_cnt;
      out_data.total_ms         <= total_cnt;
      out_data.us_per_interrupt <= est;
      out_data.frame_ms         <= (cmd_r == CMD_FRAME) ? finished : 32'd0;
    end
  end

  // checks
  a_acc_below_ms: assert property (@(posedge clk) disable iff (rst)
    acc < 10'(US_PER_MS))
    else $error("sub-millisecond accumulator out of range");

  a_irq_saturates: assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_data.cmd == CMD_TICK && irq_cnt == 16'hFFFF) |=> irq_cnt == 16'hFFFF)
    else $error("interrupt counter wrapped");

  a_frame_clears: assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_data.cmd == CMD_FRAME) |=> (frame_cnt == 32'd0 && acc == 10'd0))
    else $error("frame counts not cleared");

  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_EMIT)
    else $error("result appeared outside emit");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> step < STEP_W'(DIV_STEPS))
    else $error("divider step out of range");

endmodule
